>>> sv/cda_pkg.sv
// ----------------------------------------------------------------------------
// cda_pkg
// Shared types, constants and small tables for the calendar date core.
// ----------------------------------------------------------------------------
package cda_pkg;

   // field widths
   localparam int FUNC_W  = 3;
   localparam int AMT_W   = 16;
   localparam int YEAR_W  = 14;
   localparam int MONTH_W = 4;
   localparam int DAY_W   = 5;
   localparam int WDAY_W  = 3;

   // command codes
   typedef enum logic [FUNC_W-1:0] {
      FUNC_LOAD       = 3'd0,
      FUNC_ADD_DAYS   = 3'd1,
      FUNC_ADD_MONTHS = 3'd2,
      FUNC_SUB_MONTHS = 3'd3,
      FUNC_ADD_YEARS  = 3'd4,
      FUNC_SUB_YEARS  = 3'd5
   } func_type;

   typedef struct packed {
      logic [FUNC_W-1:0]  func;
      logic [AMT_W-1:0]   amount;
      logic [YEAR_W-1:0]  load_year;
      logic [MONTH_W-1:0] load_month;
      logic [DAY_W-1:0]   load_day;
   } req_type;

   typedef struct packed {
      logic [YEAR_W-1:0]  out_year;
      logic [MONTH_W-1:0] out_month;
      logic [DAY_W-1:0]   out_day;
      logic [WDAY_W-1:0]  weekday;
      logic               status;
   } rsp_type;

   // months
   localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
   localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
   localparam logic [MONTH_W-1:0] MONTH_MAR = 4'd3;
   localparam logic [MONTH_W-1:0] MONTH_APR = 4'd4;
   localparam logic [MONTH_W-1:0] MONTH_JUN = 4'd6;
   localparam logic [MONTH_W-1:0] MONTH_SEP = 4'd9;
   localparam logic [MONTH_W-1:0] MONTH_NOV = 4'd11;
   localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;
   localparam logic [MONTH_W-1:0] MONTHS_PER_YEAR = 4'd12;

   localparam logic [DAY_W-1:0] DAY_FIRST    = 5'd1;
   localparam logic [DAY_W-1:0] DAY_LEAP_FEB = 5'd29;
   localparam logic [DAY_W-1:0] DAY_DEC_LAST = 5'd31;

   // state after reset: 1 January 2001 (not a leap year)
   localparam logic [YEAR_W-1:0] RESET_YEAR = 14'd2001;

   // y / 25 = (y * 5243) >> 17, exact for y < 2**14
   localparam int RECIP25_W = 13;
   localparam logic [RECIP25_W-1:0] RECIP25 = 13'd5243;
   localparam int REC25_SHIFT = 17;
   localparam int Q25_W = YEAR_W + RECIP25_W - REC25_SHIFT;

   // n / 12 = (n * 43691) >> 19, exact for n < 2**16
   localparam int RECIP12_W = 16;
   localparam logic [RECIP12_W-1:0] RECIP12 = 16'd43691;
   localparam int REC12_SHIFT = 19;

   // weekday: year is biased by 400 so Jan/Feb of year 0 stay positive
   localparam int ZY_W = YEAR_W + 1;
   localparam logic [ZY_W-1:0] ZELLER_BIAS = 15'd400;
   localparam logic [MONTH_W-1:0] ZELLER_MONTH_SHIFT = 4'd12;
   // yy / 100 = (yy * 5243) >> 19, exact for yy < 2**15
   localparam int RECIP100_W = 13;
   localparam logic [RECIP100_W-1:0] RECIP100 = 13'd5243;
   localparam int REC100_SHIFT = 19;
   localparam int ZJ_W = 8;   // century, at most 167
   localparam int ZK_W = 7;   // year of century
   localparam int ZS_W = 11;  // weekday sum, at most 1069
   // s / 7 = (s * 2341) >> 14, exact for s < 2**11
   localparam int RECIP7_W = 12;
   localparam logic [RECIP7_W-1:0] RECIP7 = 12'd2341;
   localparam int REC7_SHIFT = 14;
   localparam int ZQ7_W = ZS_W + RECIP7_W - REC7_SHIFT;

   // controller -> datapath
   typedef struct packed {
      logic capture;   // take the request
      logic split;     // amount -> whole years and leftover months
      logic apply;     // main date update
      logic leap;      // refresh leap flag from the year
      logic adjust;    // clamp day / February 29 fixup
      logic day_step;  // one month of day addition
      logic zmul;      // weekday: century
      logic zsum;      // weekday: Zeller sum
      logic zmod;      // weekday: mod 7, load result register
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic [FUNC_W-1:0] func;
      logic              day_fits;      // remaining days fit in this month
      logic              day_year_end;  // current month is December
      logic              day_at_max;    // year at the upper limit
   } stat_type;

   function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] month,
                                                  input logic leap);
      logic [DAY_W-1:0] len;
      unique case (month)
         MONTH_FEB: len = leap ? 5'd29 : 5'd28;
         MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: len = 5'd30;
         default: len = 5'd31;
      endcase
      return len;
   endfunction

   // floor(26 * (mm + 1) / 10) for mm in 3..14
   function automatic logic [5:0] zeller_month_term(input logic [MONTH_W-1:0] mm);
      logic [5:0] term;
      unique case (mm)
         4'd3:    term = 6'd10;
         4'd4:    term = 6'd13;
         4'd5:    term = 6'd15;
         4'd6:    term = 6'd18;
         4'd7:    term = 6'd20;
         4'd8:    term = 6'd23;
         4'd9:    term = 6'd26;
         4'd10:   term = 6'd28;
         4'd11:   term = 6'd31;
         4'd12:   term = 6'd33;
         4'd13:   term = 6'd36;
         4'd14:   term = 6'd39;
         default: term = 6'd0;
      endcase
      return term;
   endfunction

endpackage

>>> sv/cda_ctrl.sv
// ----------------------------------------------------------------------------
// cda_ctrl
// Sequencer for the date core: walks each request through the datapath steps.
// ----------------------------------------------------------------------------
module cda_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output cda_pkg::cmd_type   cmd,
   input  cda_pkg::stat_type  stat
);

   typedef enum logic [8:0] {
      ST_IDLE  = 9'b000000001,
      ST_SPLIT = 9'b000000010,
      ST_APPLY = 9'b000000100,
      ST_LEAP  = 9'b000001000,
      ST_ADJ   = 9'b000010000,
      ST_DAYS  = 9'b000100000,
      ST_ZMUL  = 9'b001000000,
      ST_ZSUM  = 9'b010000000,
      ST_ZMOD  = 9'b100000000
   } state_type;

   state_type state_ff, state_in;
   logic      fin_ff, fin_in;        // day addition ended by saturation
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in     = state_ff;
      fin_in       = fin_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      cmd          = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               fin_in      = 1'b0;
               state_in    = ST_SPLIT;
            end
         end
         ST_SPLIT: begin
            cmd.split = 1'b1;
            state_in  = ST_APPLY;
         end
         ST_APPLY: begin
            cmd.apply = 1'b1;
            state_in  = ST_LEAP;
         end
         ST_LEAP: begin
            cmd.leap = 1'b1;
            if (stat.func == cda_pkg::FUNC_ADD_DAYS && !fin_ff) begin
               state_in = ST_DAYS;
            end else begin
               state_in = ST_ADJ;
            end
         end
         ST_ADJ: begin
            cmd.adjust = 1'b1;
            state_in   = ST_ZMUL;
         end
         ST_DAYS: begin
            cmd.day_step = 1'b1;
            priority if (stat.day_fits) begin
               state_in = ST_ZMUL;
            end else if (stat.day_year_end) begin
               // new year (or saturation): leap flag must follow
               fin_in   = stat.day_at_max;
               state_in = ST_LEAP;
            end else begin
               state_in = ST_DAYS;
            end
         end
         ST_ZMUL: begin
            cmd.zmul = 1'b1;
            state_in = ST_ZSUM;
         end
         ST_ZSUM: begin
            cmd.zsum = 1'b1;
            state_in = ST_ZMOD;
         end
         ST_ZMOD: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.zmod     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fin_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fin_ff       <= fin_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   a_rsp_from_zmod: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_ZMOD))
      else $error("result appeared outside the final weekday step");

   a_zmod_waits: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ZMOD && rsp_valid_ff && rsp_stall) |=> (state_ff == ST_ZMOD))
      else $error("finished result left ZMOD while output register was full");

   a_fin_days_only: assert property (@(posedge clock) disable iff (reset)
      fin_ff |-> (stat.func == cda_pkg::FUNC_ADD_DAYS))
      else $error("saturation flag set outside day addition");

endmodule

>>> sv/cda_dp.sv
// ----------------------------------------------------------------------------
// cda_dp
// Date registers, month/year arithmetic, leap flag and weekday pipeline.
// ----------------------------------------------------------------------------
module cda_dp #(
   parameter int AMOUNT_BITS = 16,
   parameter int MAX_YEAR    = 9999
) (
   input  logic               clock,
   input  logic               reset,
   input  cda_pkg::cmd_type   cmd,
   output cda_pkg::stat_type  stat,
   input  cda_pkg::req_type   req_data,
   output cda_pkg::rsp_type   rsp_data
);

   localparam int YW = cda_pkg::YEAR_W;
   localparam int MW = cda_pkg::MONTH_W;
   localparam int DW = cda_pkg::DAY_W;
   localparam int WW = cda_pkg::WDAY_W;
   localparam int NB = (AMOUNT_BITS < cda_pkg::AMT_W) ? AMOUNT_BITS : cda_pkg::AMT_W;
   localparam int CW = (NB > DW) ? NB : DW;
   localparam int SW = ((NB > YW) ? NB : YW) + 2;
   localparam int P25_W  = YW + cda_pkg::RECIP25_W;
   localparam int P12_W  = NB + cda_pkg::RECIP12_W;
   localparam int ZYW    = cda_pkg::ZY_W;
   localparam int P100_W = ZYW + cda_pkg::RECIP100_W;
   localparam int ZJW    = cda_pkg::ZJ_W;
   localparam int ZKW    = cda_pkg::ZK_W;
   localparam int ZSW    = cda_pkg::ZS_W;
   localparam int P7_W   = ZSW + cda_pkg::RECIP7_W;
   localparam int ZQW    = cda_pkg::ZQ7_W;
   localparam int Q25W   = cda_pkg::Q25_W;
   localparam logic [YW-1:0] MAX_Y = YW'(MAX_YEAR);

   // request
   logic [cda_pkg::FUNC_W-1:0] func_ff;
   logic [NB-1:0]              n_ff;
   logic [YW-1:0]              ldy_ff;
   logic [MW-1:0]              ldm_ff;
   logic [DW-1:0]              ldd_ff;

   // date state
   logic [YW-1:0] year_ff,  year_in;
   logic [MW-1:0] month_ff, month_in;
   logic [DW-1:0] day_ff,   day_in;
   logic          leap_ff,  leap_in;
   logic          status_ff, status_in;
   logic [NB-1:0] n_in;

   logic [NB-1:0] q_ff;
   logic [MW-1:0] r_ff;
   logic [ZJW-1:0] zj_ff;
   logic [ZSW-1:0] zsum_ff;
   cda_pkg::rsp_type rsp_ff;

   // ---- leap year: div by 4, and not by 100 unless by 400 ----
   logic [P25_W-1:0] prod25;
   logic [Q25W-1:0]  q25;
   logic [YW-1:0]    q25x25;
   logic             div25, leap_calc;

   assign prod25    = P25_W'(year_ff) * P25_W'(cda_pkg::RECIP25);
   assign q25       = Q25W'(prod25 >> cda_pkg::REC25_SHIFT);
   assign q25x25    = (YW'(q25) << 4) + (YW'(q25) << 3) + YW'(q25);
   assign div25     = (q25x25 == year_ff);
   assign leap_calc = (year_ff[1:0] == 2'd0) && (!div25 || year_ff[3:0] == 4'd0);

   logic [DW-1:0] len;
   assign len = cda_pkg::month_len(month_ff, leap_ff);

   // ---- amount split into years and months ----
   logic [P12_W-1:0] prod12;
   logic [NB-1:0]    q12, r12;
   assign prod12 = P12_W'(n_ff) * P12_W'(cda_pkg::RECIP12);
   assign q12    = NB'(prod12 >> cda_pkg::REC12_SHIFT);
   assign r12    = n_ff - ((q12 << 3) + (q12 << 2));

   // ---- month arithmetic ----
   logic [MW-1:0] month0, madd_wrap, msub_wrap;
   logic [MW:0]   madd, msub;
   logic          mcarry, mborrow;
   logic [SW-1:0] year_x, q_x, n_x, max_x, ny_add, ny_sub, yadd;

   assign month0    = month_ff - MW'(1);
   assign madd      = {1'b0, month0} + {1'b0, r_ff};
   assign mcarry    = (madd >= {1'b0, cda_pkg::MONTHS_PER_YEAR});
   assign madd_wrap = mcarry ? MW'(madd - {1'b0, cda_pkg::MONTHS_PER_YEAR}) : MW'(madd);
   assign msub      = {1'b0, month0} - {1'b0, r_ff};
   assign mborrow   = msub[MW];
   assign msub_wrap = mborrow ? MW'(msub + {1'b0, cda_pkg::MONTHS_PER_YEAR}) : MW'(msub);

   assign year_x = SW'(year_ff);
   assign q_x    = SW'(q_ff);
   assign n_x    = SW'(n_ff);
   assign max_x  = SW'(MAX_Y);
   assign ny_add = year_x + q_x + SW'(mcarry);
   assign ny_sub = year_x - q_x - SW'(mborrow);
   assign yadd   = year_x + n_x;

   // ---- one month of day addition ----
   logic [DW-1:0] left;
   logic [CW-1:0] n_c, left_c;
   logic          day_fits;
   assign left     = len - day_ff;
   assign n_c      = CW'(n_ff);
   assign left_c   = CW'(left);
   assign day_fits = (n_c <= left_c);

   // ---- weekday ----
   logic            early;
   logic [ZYW-1:0]  yy;
   logic [MW-1:0]   mm;
   logic [P100_W-1:0] prod100;
   logic [ZYW-1:0]  k_full;
   logic [ZKW-1:0]  zk;
   logic [ZSW-1:0]  zsum;
   logic [P7_W-1:0] prod7;
   logic [ZQW-1:0]  q7;
   logic [ZSW-1:0]  q7x7;
   logic [WW-1:0]   wd;

   assign early   = (month_ff < cda_pkg::MONTH_MAR);
   assign yy      = ZYW'(year_ff) + cda_pkg::ZELLER_BIAS - ZYW'(early);
   assign mm      = early ? month_ff + cda_pkg::ZELLER_MONTH_SHIFT : month_ff;
   assign prod100 = P100_W'(yy) * P100_W'(cda_pkg::RECIP100);
   assign k_full  = yy - ((ZYW'(zj_ff) << 6) + (ZYW'(zj_ff) << 5) + (ZYW'(zj_ff) << 2));
   assign zk      = k_full[ZKW-1:0];
   assign zsum    = ZSW'(day_ff) + ZSW'(cda_pkg::zeller_month_term(mm)) + ZSW'(zk)
                  + ZSW'(zk >> 2) + ZSW'(zj_ff >> 2) + (ZSW'(zj_ff) << 2) + ZSW'(zj_ff);
   assign prod7   = P7_W'(zsum_ff) * P7_W'(cda_pkg::RECIP7);
   assign q7      = ZQW'(prod7 >> cda_pkg::REC7_SHIFT);
   assign q7x7    = (ZSW'(q7) << 3) - ZSW'(q7);
   assign wd      = WW'(zsum_ff - q7x7);

   // ---- date next-state ----
   always_comb begin
      year_in   = year_ff;
      month_in  = month_ff;
      day_in    = day_ff;
      leap_in   = leap_ff;
      status_in = status_ff;
      n_in      = n_ff;
      priority if (cmd.capture) begin
         status_in = 1'b0;
         n_in      = req_data.amount[NB-1:0];
      end else if (cmd.apply) begin
         unique case (func_ff)
            cda_pkg::FUNC_LOAD: begin
               if (ldy_ff > MAX_Y) begin
                  year_in   = MAX_Y;
                  status_in = 1'b1;
               end else begin
                  year_in = ldy_ff;
               end
               if (ldm_ff == '0) begin
                  month_in = cda_pkg::MONTH_JAN;
               end else if (ldm_ff > cda_pkg::MONTH_DEC) begin
                  month_in = cda_pkg::MONTH_DEC;
               end else begin
                  month_in = ldm_ff;
               end
               day_in = (ldd_ff == '0) ? cda_pkg::DAY_FIRST : ldd_ff;
            end
            cda_pkg::FUNC_ADD_MONTHS: begin
               if (ny_add > max_x) begin
                  year_in   = MAX_Y;
                  month_in  = cda_pkg::MONTH_DEC;
                  day_in    = cda_pkg::DAY_DEC_LAST;
                  status_in = 1'b1;
               end else begin
                  year_in  = YW'(ny_add);
                  month_in = madd_wrap + MW'(1);
               end
            end
            cda_pkg::FUNC_SUB_MONTHS: begin
               if (ny_sub[SW-1]) begin
                  year_in   = '0;
                  month_in  = cda_pkg::MONTH_JAN;
                  day_in    = cda_pkg::DAY_FIRST;
                  status_in = 1'b1;
               end else begin
                  year_in  = YW'(ny_sub);
                  month_in = msub_wrap + MW'(1);
               end
            end
            cda_pkg::FUNC_ADD_YEARS: begin
               if (yadd > max_x) begin
                  year_in   = MAX_Y;
                  month_in  = cda_pkg::MONTH_DEC;
                  day_in    = cda_pkg::DAY_DEC_LAST;
                  status_in = 1'b1;
               end else begin
                  year_in = YW'(yadd);
               end
            end
            cda_pkg::FUNC_SUB_YEARS: begin
               if (n_x > year_x) begin
                  year_in   = '0;
                  month_in  = cda_pkg::MONTH_JAN;
                  day_in    = cda_pkg::DAY_FIRST;
                  status_in = 1'b1;
               end else begin
                  year_in = YW'(year_x - n_x);
               end
            end
            default: begin
            end
         endcase
      end else if (cmd.leap) begin
         leap_in = leap_calc;
      end else if (cmd.adjust) begin
         unique case (func_ff)
            cda_pkg::FUNC_LOAD, cda_pkg::FUNC_ADD_MONTHS, cda_pkg::FUNC_SUB_MONTHS: begin
               if (day_ff > len) begin
                  day_in = len;
               end
            end
            cda_pkg::FUNC_ADD_YEARS, cda_pkg::FUNC_SUB_YEARS: begin
               if (month_ff == cda_pkg::MONTH_FEB && day_ff == cda_pkg::DAY_LEAP_FEB
                   && !leap_ff) begin
                  month_in = cda_pkg::MONTH_MAR;
                  day_in   = cda_pkg::DAY_FIRST;
               end
            end
            default: begin
            end
         endcase
      end else if (cmd.day_step) begin
         if (day_fits) begin
            day_in = day_ff + n_c[DW-1:0];
         end else begin
            n_in   = NB'(n_c - left_c - CW'(1));
            day_in = cda_pkg::DAY_FIRST;
            if (month_ff == cda_pkg::MONTH_DEC) begin
               if (year_ff >= MAX_Y) begin
                  year_in   = MAX_Y;
                  month_in  = cda_pkg::MONTH_DEC;
                  day_in    = cda_pkg::DAY_DEC_LAST;
                  status_in = 1'b1;
               end else begin
                  year_in  = year_ff + YW'(1);
                  month_in = cda_pkg::MONTH_JAN;
               end
            end else begin
               month_in = month_ff + MW'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         year_ff  <= cda_pkg::RESET_YEAR;
         month_ff <= cda_pkg::MONTH_JAN;
         day_ff   <= cda_pkg::DAY_FIRST;
         leap_ff  <= 1'b0;
      end else begin
         year_ff  <= year_in;
         month_ff <= month_in;
         day_ff   <= day_in;
         leap_ff  <= leap_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff <= status_in;
      n_ff      <= n_in;
      if (cmd.capture) begin
         func_ff <= req_data.func;
         ldy_ff  <= req_data.load_year;
         ldm_ff  <= req_data.load_month;
         ldd_ff  <= req_data.load_day;
      end
      if (cmd.split) begin
         q_ff <= q12;
         r_ff <= r12[MW-1:0];
      end
      if (cmd.zmul) begin
         zj_ff <= ZJW'(prod100 >> cda_pkg::REC100_SHIFT);
      end
      if (cmd.zsum) begin
         zsum_ff <= zsum;
      end
      if (cmd.zmod) begin
         rsp_ff.out_year  <= year_ff;
         rsp_ff.out_month <= month_ff;
         rsp_ff.out_day   <= day_ff;
         rsp_ff.weekday   <= wd;
         rsp_ff.status    <= status_ff;
      end
   end

   assign stat.func         = func_ff;
   assign stat.day_fits     = day_fits;
   assign stat.day_year_end = (month_ff == cda_pkg::MONTH_DEC);
   assign stat.day_at_max   = (year_ff >= MAX_Y);
   assign rsp_data          = rsp_ff;

   a_month_range: assert property (@(posedge clock) disable iff (reset)
      (month_ff >= cda_pkg::MONTH_JAN) && (month_ff <= cda_pkg::MONTH_DEC))
      else $error("month register out of range");

   a_day_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.zmod |-> (day_ff != '0) && (day_ff <= len))
      else $error("reported day outside its month");

   a_leap_current: assert property (@(posedge clock) disable iff (reset)
      cmd.zmod |-> (leap_ff == leap_calc))
      else $error("leap flag stale at result time");

endmodule

>>> sv/calendar_date_arithmetic_core.sv
// ----------------------------------------------------------------------------
// calendar_date_arithmetic_core
// Gregorian date register with load, day/month/year arithmetic and weekday.
// ----------------------------------------------------------------------------
// Holds one date (reset: 1 January 2001). Each request loads a date or adds
// days, adds/subtracts months or adds/subtracts years, and returns exactly one
// response: the new date, its weekday (0 Saturday .. 6 Friday) and a status
// bit that is set when the year saturated (to MAX_YEAR, 31 Dec unless it was
// a load; or to 1 Jan year 0). One request is in work at a time. Load, month
// and year requests pass through the capture, split, apply, leap, adjust and
// weekday steps before the response is registered. Adding days walks one
// month per cycle and returns to the leap step at each new year to refresh
// the leap flag. The next request is taken as soon as the previous one has
// finished its weekday step, even if its response is still stalled.
// ----------------------------------------------------------------------------
module calendar_date_arithmetic_core #(
   parameter int AMOUNT_BITS = 16,   // low bits of amount that are used
   parameter int MAX_YEAR    = 9999  // upper year limit
) (
   input  logic              clock,
   input  logic              reset,
   // request channel
   input  logic              req_valid,
   output logic              req_stall,
   input  cda_pkg::req_type  req_data,
   // response channel
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output cda_pkg::rsp_type  rsp_data
);

   // command/status bundle between sequencer and datapath
   cda_pkg::cmd_type  cmd;
   cda_pkg::stat_type stat;

   // sequencer: one-hot state machine, owns handshakes and response valid
   cda_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .stat      (stat)
   );

   // datapath: date registers, reciprocal dividers, weekday pipe,
   // response register
   cda_dp #(
      .AMOUNT_BITS (AMOUNT_BITS),
      .MAX_YEAR    (MAX_YEAR)
   ) u_dp (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .stat     (stat),
      .req_data (req_data),
      .rsp_data (rsp_data)
   );

endmodule
